// File: sv/qpdm_pkg.sv
// qpdm_pkg: constellation levels, mode codes and point lookup for the
// QAM point distance block. No dependencies.
package qpdm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MODE_W           = 2;
  localparam int IDX_W            = 6;
  localparam int DIST_W           = 32;
  // Signed width of one constellation coordinate (largest is 4424)
  localparam int CRD_W            = 14;

  typedef enum logic [MODE_W-1:0] {
    MODE_BPSK  = 2'd0,
    MODE_QPSK  = 2'd1,
    MODE_QAM16 = 2'd2,
    MODE_QAM64 = 2'd3
  } mod_mode_t;

  typedef logic signed [CRD_W-1:0] crd_val_t;

  typedef struct packed {
    crd_val_t ci;
    crd_val_t cq;
  } crd_t;

  // Unit-energy levels rounded to Q3.12
  localparam crd_val_t LVL_BPSK = 14'sd4096;
  localparam crd_val_t LVL_QPSK = 14'sd2896;
  localparam crd_val_t LVL_16 [2] = '{14'sd1295, 14'sd3886};
  localparam crd_val_t LVL_64 [4] = '{14'sd632, 14'sd1896, 14'sd3160, 14'sd4424};

  // Index of the final point of a run
  function automatic logic [IDX_W-1:0] last_idx(mod_mode_t mode);
    logic [IDX_W-1:0] r;
    unique case (mode)
      MODE_BPSK:  r = 6'd1;
      MODE_QPSK:  r = 6'd3;
      MODE_QAM16: r = 6'd15;
      MODE_QAM64: r = 6'd63;
      default:    r = 6'd1;
    endcase
    return r;
  endfunction

  // Coordinates of point idx in table order; sign bit set means negative
  function automatic crd_t point_crd(mod_mode_t mode, logic [IDX_W-1:0] idx);
    logic     si;
    logic     sq;
    crd_val_t mi;
    crd_val_t mq;
    crd_t     c;
    unique case (mode)
      MODE_BPSK: begin
        si = idx[0];
        sq = 1'b0;
        mi = LVL_BPSK;
        mq = '0;
      end
      MODE_QPSK: begin
        si = idx[1];
        sq = idx[0];
        mi = LVL_QPSK;
        mq = LVL_QPSK;
      end
      MODE_QAM16: begin
        si = idx[3];
        sq = idx[2];
        mi = LVL_16[idx[1]];
        mq = LVL_16[idx[0]];
      end
      default: begin
        si = idx[5];
        sq = idx[4];
        mi = LVL_64[idx[3:2]];
        mq = LVL_64[idx[1:0]];
      end
    endcase
    c.ci = si ? -mi : mi;
    c.cq = sq ? -mq : mq;
    return c;
  endfunction

endpackage

// File: sv/qpdm_if.sv
// qpdm_if: valid/ready stream interfaces for the sample words and the
// distance words. Depends on qpdm_pkg for field widths.
interface qpdm_sample_if
  import qpdm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface qpdm_metric_if
  import qpdm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  point_index;
  logic [DIST_W-1:0] sq_distance;
  logic              last_point;

  modport source (output valid, output point_index, output sq_distance,
                  output last_point, input ready);
  modport sink   (input valid, input point_index, input sq_distance,
                  input last_point, output ready);
endinterface

// File: sv/qam_point_distance_metrics.sv
// qam_point_distance_metrics: squared Euclidean distance from one I/Q
// sample to every point of the selected constellation.
// Depends on qpdm_pkg and the stream interfaces in qpdm_if.sv.
//
//   channel   dir  word                                   handshake
//   in_smp    in   sample_i, sample_q (Q3.12, signed)     valid/ready
//   out_met   out  point_index, sq_distance, last_point   valid/ready
//   cfg_*     in   mod_mode (2 bits)                      write enable
//
// A sample yields 2, 4, 16 or 64 distance words (BPSK, QPSK, 16-QAM, 64-QAM):
// one distance word leaves per cycle while out_met does not stall, set by the single point counter.
// The next sample is taken in the cycle the last word of the current one
// is loaded, so runs follow back to back with no bubble.
// Reset (synchronous, rst_n low) clears the valids and sets BPSK mode.
// A stall on out_met holds the output register and freezes the counter.
module qam_point_distance_metrics
  import qpdm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [MODE_W-1:0]       cfg_wdata,
  qpdm_sample_if.sink             in_smp,
  qpdm_metric_if.source           out_met
);

  // Difference width covers sample range plus coordinate offset
  localparam int DIF_W = ((SAMPLE_WIDTH > CRD_W) ? SAMPLE_WIDTH : CRD_W) + 1;
  localparam int MAG_W = DIF_W - 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int SUM_X = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  mod_mode_t                      mode_r;

  // Held sample and point counter
  logic                           smp_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] smp_i_r;
  logic signed [SAMPLE_WIDTH-1:0] smp_q_r;
  logic [IDX_W-1:0]               cnt_r;
  logic [IDX_W-1:0]               cnt_nxt;

  // Output register
  logic                           out_vld_r;
  logic [IDX_W-1:0]               out_idx_r;
  logic [DIST_W-1:0]              out_dist_r;
  logic                           out_last_r;

  logic                           in_acc;
  logic                           adv;
  logic                           is_last;
  crd_t                           crd;
  logic signed [DIF_W-1:0]        di;
  logic signed [DIF_W-1:0]        dq;
  logic signed [DIF_W-1:0]        adi;
  logic signed [DIF_W-1:0]        adq;
  logic [MAG_W-1:0]               mi;
  logic [MAG_W-1:0]               mq;
  logic [SUM_X-1:0]               sum_x;
  logic [DIST_W-1:0]              dist_nxt;

  // Output register moves when a sample is held and it is empty or drained
  assign adv     = smp_vld_r && (!out_vld_r || out_met.ready);
  assign is_last = (cnt_r == last_idx(mode_r));
  assign in_acc  = in_smp.valid && in_smp.ready;
  assign in_smp.ready = !smp_vld_r || (adv && is_last);
  assign cnt_nxt = cnt_r + 1'b1;

  // Datapath: point lookup, differences, two squares and their sum
  always_comb begin
    crd   = point_crd(mode_r, cnt_r);
    di    = DIF_W'(smp_i_r) - DIF_W'(crd.ci);
    dq    = DIF_W'(smp_q_r) - DIF_W'(crd.cq);
    adi   = di[DIF_W-1] ? -di : di;
    adq   = dq[DIF_W-1] ? -dq : dq;
    mi    = adi[MAG_W-1:0];
    mq    = adq[MAG_W-1:0];
    sum_x = SUM_X'(mi * mi) + SUM_X'(mq * mq);
    // Saturation only reachable at wide sample settings
    if (sum_x > SUM_X'({DIST_W{1'b1}})) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = sum_x[DIST_W-1:0];
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BPSK;
    end else if (cfg_we) begin
      mode_r <= mod_mode_t'(cfg_wdata);
    end
  end

  // Sample hold and point counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else if (in_acc) begin
      smp_vld_r <= 1'b1;
      cnt_r     <= '0;
    end else if (adv) begin
      if (is_last) begin
        smp_vld_r <= 1'b0;
        cnt_r     <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_i_r <= in_smp.sample_i;
      smp_q_r <= in_smp.sample_q;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_met.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= cnt_r;
      out_dist_r <= dist_nxt;
      out_last_r <= is_last;
    end
  end

  assign out_met.valid       = out_vld_r;
  assign out_met.point_index = out_idx_r;
  assign out_met.sq_distance = out_dist_r;
  assign out_met.last_point  = out_last_r;

endmodule

// File: bench/qam_point_distance_metrics_tb.sv
// qam_point_distance_metrics_tb: self-checking bench for the QAM point distance block.
// Depends on qpdm_pkg, the stream interfaces in qpdm_if.sv and the block itself.
module qam_point_distance_metrics_tb;
  import qpdm_pkg::*;

  localparam int SMP_W       = 16;
  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake on either channel
  localparam int TAIL_CYCLES = 70;     // a 64-QAM run plus some slack

  // Q3.12 levels, kept apart from the package tables
  localparam int BPSK_LVL = 4096;
  localparam int QPSK_LVL = 2896;
  localparam int QAM16_LVL [2] = '{1295, 3886};
  localparam int QAM64_LVL [4] = '{632, 1896, 3160, 4424};

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sqd;
    logic              last;
  } metric_word_t;

  // Hand-typed distance for one point of a directed row (tix < 0: none)
  typedef struct {
    int                tix;
    logic [DIST_W-1:0] tdist;
  } typed_note_t;

  typedef struct packed {
    mod_mode_t               mode;
    logic signed [SMP_W-1:0] xi;
    logic signed [SMP_W-1:0] xq;
    int                      tix;
    logic [DIST_W-1:0]       tdist;
  } stim_row_t;

  // Directed rows. The typed distance is used instead of the predicted one for
  // that point; all other points come from the predictor.
  localparam stim_row_t STIM_ROWS [20] = '{
    // reset mode: BPSK, origin is 1.0 away from both points
    '{MODE_BPSK,  16'sd0,      16'sd0,      0,  32'd16777216},
    '{MODE_BPSK,  16'sd4096,   16'sd0,      0,  32'd0},
    '{MODE_BPSK,  16'sh8000,   16'sh8000,   0,  32'd2432696320},
    '{MODE_BPSK,  16'sh7fff,   16'sh7fff,   -1, 32'd0},
    '{MODE_BPSK,  -16'sd1,     16'sd1,      -1, 32'd0},
    '{MODE_QPSK,  16'sd0,      16'sd0,      0,  32'd16773632},
    '{MODE_QPSK,  16'sd2896,   -16'sd2896,  1,  32'd0},
    '{MODE_QPSK,  16'sh8000,   16'sh7fff,   -1, 32'd0},
    '{MODE_QPSK,  16'sh7fff,   16'sh8000,   -1, 32'd0},
    '{MODE_QAM16, 16'sd0,      16'sd0,      -1, 32'd0},
    '{MODE_QAM16, 16'sd3886,   -16'sd3886,  7,  32'd0},
    '{MODE_QAM16, 16'sh8000,   16'sh8000,   -1, 32'd0},
    '{MODE_QAM16, 16'sh7fff,   16'sh7fff,   -1, 32'd0},
    '{MODE_QAM16, 16'sh5555,   16'shaaaa,   -1, 32'd0},
    // largest distance of all: far corner to the +7,+7 point
    '{MODE_QAM64, 16'sh8000,   16'sh8000,   15, 32'd2766489728},
    '{MODE_QAM64, -16'sd632,   -16'sd632,   48, 32'd0},
    '{MODE_QAM64, 16'sh7fff,   16'sh7fff,   -1, 32'd0},
    '{MODE_QAM64, 16'sd0,      16'sd0,      -1, 32'd0},
    '{MODE_QAM64, 16'shaaaa,   16'sh5555,   -1, 32'd0},
    '{MODE_BPSK,  16'sd1,      -16'sd1,     -1, 32'd0}
  };

  // Mode order of the random segments, repeated in every idling phase
  localparam mod_mode_t RAND_MODES [4] = '{MODE_QAM64, MODE_QPSK, MODE_BPSK, MODE_QAM16};

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  qpdm_sample_if #(.SAMPLE_WIDTH(SMP_W)) smp_if ();
  qpdm_metric_if                         met_if ();

  qam_point_distance_metrics #(
    .SAMPLE_WIDTH (SMP_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_smp    (smp_if),
    .out_met   (met_if)
  );

  metric_word_t pending_metrics [$];   // distance words still owed by the block
  typed_note_t  typed_notes [$];       // one per sample, in send order
  mod_mode_t    cur_mode = MODE_BPSK;  // mirror of the mode register
  int           snd_gap_pct;
  int           rcv_gap_pct;
  int           quiet_cycles;
  bit           broken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned point_count(mod_mode_t m);
    case (m)
      MODE_BPSK:  return 2;
      MODE_QPSK:  return 4;
      MODE_QAM16: return 16;
      default:    return 64;
    endcase
  endfunction

  // Exact squared distance in Q8.24 from (xi, xq) to point k of mode m
  function automatic logic [DIST_W-1:0] sq_distance_to(mod_mode_t m, logic [IDX_W-1:0] k,
                                                        logic signed [SMP_W-1:0] xi,
                                                        logic signed [SMP_W-1:0] xq);
    longint pi;
    longint pq;
    longint di;
    longint dq;
    longint d;
    case (m)
      MODE_BPSK: begin
        pi = k[0] ? -BPSK_LVL : BPSK_LVL;
        pq = 0;
      end
      MODE_QPSK: begin
        pi = k[1] ? -QPSK_LVL : QPSK_LVL;
        pq = k[0] ? -QPSK_LVL : QPSK_LVL;
      end
      MODE_QAM16: begin
        pi = k[3] ? -QAM16_LVL[k[1]] : QAM16_LVL[k[1]];
        pq = k[2] ? -QAM16_LVL[k[0]] : QAM16_LVL[k[0]];
      end
      default: begin
        pi = k[5] ? -QAM64_LVL[k[3:2]] : QAM64_LVL[k[3:2]];
        pq = k[4] ? -QAM64_LVL[k[1:0]] : QAM64_LVL[k[1:0]];
      end
    endcase
    di = longint'(xi) - pi;
    dq = longint'(xq) - pq;
    d  = di * di + dq * dq;
    // saturation only reachable with wider samples
    if (d > 64'hffff_ffff) d = 64'hffff_ffff;
    return d[DIST_W-1:0];
  endfunction

  // Mostly noisy constellation points, some raw words, some rail values
  function automatic logic signed [SMP_W-1:0] rand_coord(mod_mode_t m);
    int pick;
    int lvl;
    pick = $urandom_range(99);
    if (pick < 25) return SMP_W'($urandom);
    if (pick < 35) begin
      case ($urandom_range(3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    case (m)
      MODE_BPSK:  lvl = BPSK_LVL;
      MODE_QPSK:  lvl = QPSK_LVL;
      MODE_QAM16: lvl = QAM16_LVL[$urandom_range(1)];
      default:    lvl = QAM64_LVL[$urandom_range(3)];
    endcase
    if ($urandom_range(1)) lvl = -lvl;
    lvl = lvl + int'($urandom_range(1023)) - 512;
    return SMP_W'(lvl);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one sample word and returns at the edge where it is taken. Valid is
  // left high so that back-to-back words need no extra edge; a gap lowers it.
  task automatic push_sample(input logic signed [SMP_W-1:0] xi,
                             input logic signed [SMP_W-1:0] xq,
                             input int tix, input logic [DIST_W-1:0] tdist);
    typed_notes.insert(typed_notes.size(), typed_note_t'{tix, tdist});
    if ($urandom_range(99) < snd_gap_pct) begin
      smp_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_gap_pct);
    end
    smp_if.valid    <= 1'b1;
    smp_if.sample_i <= xi;
    smp_if.sample_q <= xq;
    do @(posedge clk); while (!smp_if.ready);
  endtask

  // Wait until every owed distance word has come out, then for extra more edges.
  // The first look follows the next edge, so a run booked at the calling edge counts.
  task automatic drain_metrics(input int extra);
    do @(posedge clk); while (pending_metrics.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Mode changes only with the block idle: no sample offered, nothing owed
  task automatic set_mode(input mod_mode_t m);
    smp_if.valid <= 1'b0;
    drain_metrics(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode  = m;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: ready toggled at random every cycle
  // ---------------------------------------------------------------------------
  initial begin
    met_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      met_if.ready <= ($urandom_range(99) >= rcv_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. Output words are checked first, then a sample taken at the same
  // edge books its run, so the order within the edge is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    metric_word_t want;
    typed_note_t  note;
    int unsigned  n_pts;
    if (rst_n && met_if.valid && met_if.ready) begin
      if (pending_metrics.size() == 0) begin
        $error("unexpected distance word: point_index %0d sq_distance %0d last_point %0b",
               met_if.point_index, met_if.sq_distance, met_if.last_point);
        broken = 1'b1;
      end else begin
        want = pending_metrics.pop_front();
        if (met_if.point_index !== want.idx) begin
          $error("point_index: expected %0d, got %0d", want.idx, met_if.point_index);
          broken = 1'b1;
        end
        if (met_if.sq_distance !== want.sqd) begin
          $error("sq_distance: expected %0d, got %0d", want.sqd, met_if.sq_distance);
          broken = 1'b1;
        end
        if (met_if.last_point !== want.last) begin
          $error("last_point: expected %0b, got %0b", want.last, met_if.last_point);
          broken = 1'b1;
        end
      end
    end
    if (rst_n && smp_if.valid && smp_if.ready) begin
      note  = typed_notes.pop_front();
      n_pts = point_count(cur_mode);
      for (int k = 0; k < n_pts; k++) begin
        want.idx  = IDX_W'(k);
        want.sqd  = (k == note.tix) ? note.tdist
                                    : sq_distance_to(cur_mode, IDX_W'(k),
                                                     smp_if.sample_i, smp_if.sample_q);
        want.last = (k + 1 == n_pts);
        pending_metrics.insert(pending_metrics.size(), want);
      end
    end
  end

  // Watchdog: a hung handshake or a lost word ends the run
  always @(posedge clk) begin
    if (!rst_n || (smp_if.valid && smp_if.ready) || (met_if.valid && met_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= MODE_BPSK;
    smp_if.valid    <= 1'b0;
    smp_if.sample_i <= '0;
    smp_if.sample_q <= '0;
    snd_gap_pct      = 15;
    rcv_gap_pct      = 82;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; the first ones rely on BPSK being the reset mode
    foreach (STIM_ROWS[r]) begin
      if (STIM_ROWS[r].mode != cur_mode) set_mode(STIM_ROWS[r].mode);
      push_sample(STIM_ROWS[r].xi, STIM_ROWS[r].xq, STIM_ROWS[r].tix, STIM_ROWS[r].tdist);
    end

    // Random part: three idling phases, each sweeping every mode
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_gap_pct = 15; rcv_gap_pct = 82; end
        1: begin snd_gap_pct = 82; rcv_gap_pct = 15; end
        default: begin snd_gap_pct = 0; rcv_gap_pct = 0; end
      endcase
      foreach (RAND_MODES[j]) begin
        set_mode(RAND_MODES[j]);
        repeat (21) push_sample(rand_coord(RAND_MODES[j]), rand_coord(RAND_MODES[j]),
                                -1, '0);
      end
    end

    smp_if.valid <= 1'b0;
    drain_metrics(TAIL_CYCLES);
    if (!broken) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/qpdm_pkg.sv
sv/qpdm_if.sv
sv/qam_point_distance_metrics.sv
bench/qam_point_distance_metrics_tb.sv
